// ===== sv/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types, codes and the glyph font of the mono framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // Default panel geometry
  localparam int DisplayWidthDef  = 128;
  localparam int DisplayHeightDef = 64;

  // Coordinate and error term widths
  localparam int CW    = 11;
  localparam int ERR_W = 14;

  // Glyph font geometry
  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_LAST  = 122;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = GLYPH_LAST - GLYPH_FIRST + 1;

  typedef enum logic [3:0] {
    OP_CLEAR  = 4'd0,
    OP_INVERT = 4'd1,
    OP_PIXEL  = 4'd2,
    OP_LINE   = 4'd3,
    OP_RECT   = 4'd4,
    OP_FILL   = 4'd5,
    OP_CIRCLE = 4'd6,
    OP_GLYPH  = 4'd7,
    OP_READ   = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    REQ_PLOT,
    REQ_CLEAR,
    REQ_INVERT,
    REQ_READ
  } req_kind_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 on;
  } point_t;

  typedef struct packed {
    req_kind_e            kind;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 on;
    logic [9:0]           addr;
  } store_req_t;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_CLEAR,
    SS_INVERT,
    SS_FLUSH,
    SS_WRITE,
    SS_READ
  } store_state_e;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_PIXEL,
    RS_LSET,
    RS_LRUN,
    RS_CIRCLE,
    RS_FILL,
    RS_GLYPH
  } raster_state_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_STORE,
    TS_DRAW
  } top_state_e;

  // Font: one entry per code, column 0 in the top byte, row 0 in bit 0
  localparam logic [8*GLYPH_COLS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44
  };

endpackage

// ===== sv/mfb_store.sv =====
// ----------------------------------------------------------------------------
// mfb_store
// Framebuffer memory with read-modify-write of single pixels, clear and
// invert sweeps and byte read-back.
// ----------------------------------------------------------------------------
module mfb_store #(
  parameter int DisplayWidth  = mfb_pkg::DisplayWidthDef,
  parameter int DisplayHeight = mfb_pkg::DisplayHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  mfb_pkg::store_req_t req_i,
  output logic                ready_o,
  output logic [7:0]          rdata_o
);
  import mfb_pkg::*;

  localparam int Pages = (DisplayHeight + 7) / 8;
  localparam int Depth = DisplayWidth * Pages;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic signed [CW-1:0] XLim = CW'(DisplayWidth);
  localparam logic signed [CW-1:0] YLim = CW'(DisplayHeight);

  logic [7:0] mem [Depth];

  store_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] paddr_q, inv_addr_q;
  logic [7:0]    mask_q, rd_q;
  logic          on_q, inv_pend_q, rd_ok_q;

  logic          take, on_screen, addr_ok, cnt_last;
  logic [AW-1:0] plot_addr;
  logic [7:0]    plot_mask;
  logic          ren, we;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    wdata;

  // Decode an incoming word
  assign take      = req_valid_i && (state_q == SS_IDLE);
  assign on_screen = (req_i.x >= 0) && (req_i.x < XLim) && (req_i.y >= 0) && (req_i.y < YLim);
  assign plot_addr = AW'(req_i.x) + AW'(AW'(req_i.y[CW-1:3]) * AW'(DisplayWidth));
  assign plot_mask = 8'd1 << req_i.y[2:0];
  assign addr_ok   = 32'(req_i.addr) < Depth;
  assign cnt_last  = cnt_q == LastAddr;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SS_IDLE: begin
        if (take) begin
          unique case (req_i.kind)
            REQ_PLOT:   state_d = on_screen ? SS_WRITE : SS_IDLE;
            REQ_CLEAR:  state_d = SS_CLEAR;
            REQ_INVERT: state_d = SS_INVERT;
            REQ_READ:   state_d = SS_READ;
            default:    state_d = SS_IDLE;
          endcase
        end
      end
      SS_CLEAR:  state_d = cnt_last ? SS_IDLE : SS_CLEAR;
      SS_INVERT: state_d = cnt_last ? SS_FLUSH : SS_INVERT;
      SS_FLUSH:  state_d = SS_IDLE;
      SS_WRITE:  state_d = SS_IDLE;
      SS_READ:   state_d = SS_IDLE;
      default:   state_d = SS_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    ready_o = state_q == SS_IDLE;
    ren     = 1'b0;
    raddr   = cnt_q;
    we      = 1'b0;
    waddr   = cnt_q;
    wdata   = 8'd0;
    cnt_d   = '0;
    unique case (state_q)
      SS_IDLE: begin
        if (take && req_i.kind == REQ_PLOT && on_screen) begin
          ren   = 1'b1;
          raddr = plot_addr;
        end else if (take && req_i.kind == REQ_READ && addr_ok) begin
          ren   = 1'b1;
          raddr = AW'(req_i.addr);
        end
      end
      SS_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end
      SS_INVERT: begin
        ren   = 1'b1;
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end
      SS_WRITE: begin
        we    = 1'b1;
        waddr = paddr_q;
        wdata = on_q ? (rd_q | mask_q) : (rd_q & ~mask_q);
      end
      default: ;
    endcase
    if (inv_pend_q) begin
      we    = 1'b1;
      waddr = inv_addr_q;
      wdata = ~rd_q;
    end
  end

  // Storage array
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr];
    end
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SS_CLEAR;
      cnt_q      <= '0;
      inv_pend_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      inv_pend_q <= state_q == SS_INVERT;
      if (take && req_i.kind == REQ_READ) begin
        rd_ok_q <= addr_ok;
      end
    end
  end

  // Hold the pixel being modified and the invert write address
  always_ff @(posedge clk_i) begin
    inv_addr_q <= cnt_q;
    if (take) begin
      paddr_q <= plot_addr;
      mask_q  <= plot_mask;
      on_q    <= req_i.on;
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : 8'd0;

endmodule

// ===== sv/mfb_raster.sv =====
// ----------------------------------------------------------------------------
// mfb_raster
// Shape sequencer: steps single pixels, lines, outline and filled rectangles,
// circles and glyphs one pixel at a time and hands each pixel to be drawn to the store.
// ----------------------------------------------------------------------------
module mfb_raster (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mfb_pkg::op_e       op_i,
  input  logic signed [8:0]  x_a_i,
  input  logic signed [8:0]  y_a_i,
  input  logic signed [8:0]  x_b_i,
  input  logic signed [8:0]  y_b_i,
  input  logic [7:0]         radius_i,
  input  logic               pixel_on_i,
  input  logic [7:0]         char_code_i,
  output logic               pt_valid_o,
  output mfb_pkg::point_t    pt_o,
  input  logic               pt_ready_i,
  output logic               idle_o
);
  import mfb_pkg::*;

  raster_state_e state_q, state_d;

  logic                    on_q, outline_q;
  logic signed [CW-1:0]    xa_q, ya_q, x1_q, y1_q;
  logic signed [8:0]       xb_q, yb_q;
  logic signed [CW-1:0]    lx_q, ly_q, lxe_q, lye_q, px_q, py_q;
  logic signed [ERR_W-1:0] dx_q, dy_q, err_q;
  logic                    sxn_q, syn_q;
  logic [1:0]              seg_q;
  logic [2:0]              oct_q, col_q, row_q;
  logic [7:0]              i_q, j_q;
  logic [8*GLYPH_COLS-1:0] glyph_q;

  logic                    step;
  logic signed [CW-1:0]    xa_e, ya_e, xb_e, yb_e, x1_c, y1_c;
  logic                    code_ok;
  logic [6:0]              gidx;
  logic signed [ERR_W:0]   e2, dx_w, dy_w;
  logic                    c1, c2, l_done;
  logic signed [ERR_W-1:0] ddx, ddy;
  logic signed [CW-1:0]    py1, px1;
  logic signed [ERR_W-1:0] err1, err2;
  logic                    c_end;
  logic                    i_last, j_last;
  logic [7:0]              col_byte;
  logic                    gbit;

  // Start decode
  assign xa_e    = CW'(x_a_i);
  assign ya_e    = CW'(y_a_i);
  assign xb_e    = CW'(x_b_i);
  assign yb_e    = CW'(y_b_i);
  assign x1_c    = xa_e + xb_e - CW'(1);
  assign y1_c    = ya_e + yb_e - CW'(1);
  assign code_ok = (char_code_i >= 8'(GLYPH_FIRST)) && (char_code_i <= 8'(GLYPH_LAST));
  assign gidx    = code_ok ? 7'(char_code_i - 8'(GLYPH_FIRST)) : 7'd0;

  // Line step terms
  assign ddx    = ERR_W'(lxe_q) - ERR_W'(lx_q);
  assign ddy    = ERR_W'(lye_q) - ERR_W'(ly_q);
  assign e2     = {err_q, 1'b0};
  assign dx_w   = (ERR_W+1)'(dx_q);
  assign dy_w   = (ERR_W+1)'(dy_q);
  assign c1     = e2 > -dy_w;
  assign c2     = e2 < dx_w;
  assign l_done = (lx_q == lxe_q) && (ly_q == lye_q);

  // Circle step terms
  always_comb begin
    py1   = (err_q <= 0) ? py_q + CW'(1) : py_q;
    err1  = (err_q <= 0) ? err_q + (ERR_W'(py1) <<< 1) + ERR_W'(1) : err_q;
    px1   = (err1 > 0) ? px_q - CW'(1) : px_q;
    err2  = (err1 > 0) ? err1 - (ERR_W'(px1) <<< 1) - ERR_W'(1) : err1;
    c_end = px1 < py1;
  end

  // Fill and glyph scan terms
  assign i_last   = $signed({1'b0, i_q}) == xb_q - 9'sd1;
  assign j_last   = $signed({1'b0, j_q}) == yb_q - 9'sd1;
  assign col_byte = glyph_q[{3'(GLYPH_COLS - 1) - col_q, 3'b000} +: 8];
  assign gbit     = col_byte[row_q];

  assign step = pt_valid_o ? pt_ready_i : (state_q != RS_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            OP_PIXEL:  state_d = RS_PIXEL;
            OP_LINE:   state_d = RS_LSET;
            OP_RECT:   state_d = RS_LSET;
            OP_FILL:   state_d = (x_b_i > 0 && y_b_i > 0) ? RS_FILL : RS_IDLE;
            OP_CIRCLE: state_d = RS_CIRCLE;
            OP_GLYPH:  state_d = RS_GLYPH;
            default:   state_d = RS_IDLE;
          endcase
        end
      end
      RS_PIXEL: if (step) state_d = RS_IDLE;
      RS_LSET:  state_d = RS_LRUN;
      RS_LRUN: begin
        if (step && l_done) begin
          state_d = (outline_q && seg_q != 2'd3) ? RS_LSET : RS_IDLE;
        end
      end
      RS_CIRCLE: if (step && oct_q == 3'd7 && c_end) state_d = RS_IDLE;
      RS_FILL:   if (step && i_last && j_last) state_d = RS_IDLE;
      RS_GLYPH: begin
        if (step && col_q == 3'(GLYPH_COLS - 1) && row_q == 3'(GLYPH_ROWS - 1)) begin
          state_d = RS_IDLE;
        end
      end
      default: state_d = RS_IDLE;
    endcase
  end

  // Pixel output
  always_comb begin
    pt_valid_o = 1'b0;
    pt_o       = '{x: xa_q, y: ya_q, on: on_q};
    idle_o     = state_q == RS_IDLE;
    unique case (state_q)
      RS_PIXEL: pt_valid_o = 1'b1;
      RS_LRUN: begin
        pt_valid_o = 1'b1;
        pt_o.x     = lx_q;
        pt_o.y     = ly_q;
      end
      RS_CIRCLE: begin
        pt_valid_o = 1'b1;
        unique case (oct_q)
          3'd0: begin pt_o.x = xa_q + px_q; pt_o.y = ya_q + py_q; end
          3'd1: begin pt_o.x = xa_q + py_q; pt_o.y = ya_q + px_q; end
          3'd2: begin pt_o.x = xa_q - py_q; pt_o.y = ya_q + px_q; end
          3'd3: begin pt_o.x = xa_q - px_q; pt_o.y = ya_q + py_q; end
          3'd4: begin pt_o.x = xa_q - px_q; pt_o.y = ya_q - py_q; end
          3'd5: begin pt_o.x = xa_q - py_q; pt_o.y = ya_q - px_q; end
          3'd6: begin pt_o.x = xa_q + py_q; pt_o.y = ya_q - px_q; end
          default: begin pt_o.x = xa_q + px_q; pt_o.y = ya_q - py_q; end
        endcase
      end
      RS_FILL: begin
        pt_valid_o = 1'b1;
        pt_o.x     = xa_q + CW'(i_q);
        pt_o.y     = ya_q + CW'(j_q);
      end
      RS_GLYPH: begin
        pt_valid_o = gbit;
        pt_o.x     = xa_q + CW'(col_q);
        pt_o.y     = ya_q + CW'(row_q);
        pt_o.on    = 1'b1;
      end
      default: ;
    endcase
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shape walkers
  always_ff @(posedge clk_i) begin
    if (state_q == RS_IDLE && start_i) begin
      on_q      <= pixel_on_i;
      outline_q <= op_i == OP_RECT;
      xa_q      <= xa_e;
      ya_q      <= ya_e;
      xb_q      <= x_b_i;
      yb_q      <= y_b_i;
      x1_q      <= x1_c;
      y1_q      <= y1_c;
      glyph_q   <= GLYPH_ROM[gidx];
      lx_q      <= xa_e;
      ly_q      <= ya_e;
      lxe_q     <= (op_i == OP_LINE) ? xb_e : x1_c;
      lye_q     <= (op_i == OP_LINE) ? yb_e : ya_e;
      seg_q     <= 2'd0;
      px_q      <= CW'(radius_i);
      py_q      <= '0;
      err_q     <= '0;
      oct_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      unique case (state_q)
        RS_LSET: begin
          dx_q  <= (ddx < 0) ? -ddx : ddx;
          dy_q  <= (ddy < 0) ? -ddy : ddy;
          err_q <= ((ddx < 0) ? -ddx : ddx) - ((ddy < 0) ? -ddy : ddy);
          sxn_q <= !(lx_q < lxe_q);
          syn_q <= !(ly_q < lye_q);
        end
        RS_LRUN: begin
          if (step && !l_done) begin
            err_q <= err_q - (c1 ? dy_q : '0) + (c2 ? dx_q : '0);
            if (c1) lx_q <= sxn_q ? lx_q - CW'(1) : lx_q + CW'(1);
            if (c2) ly_q <= syn_q ? ly_q - CW'(1) : ly_q + CW'(1);
          end else if (step) begin
            seg_q <= seg_q + 2'd1;
            unique case (seg_q)
              2'd0:    begin lxe_q <= x1_q; lye_q <= y1_q; end
              2'd1:    begin lxe_q <= xa_q; lye_q <= y1_q; end
              default: begin lxe_q <= xa_q; lye_q <= ya_q; end
            endcase
          end
        end
        RS_CIRCLE: begin
          if (step) begin
            oct_q <= oct_q + 3'd1;
            if (oct_q == 3'd7) begin
              px_q  <= px1;
              py_q  <= py1;
              err_q <= err2;
            end
          end
        end
        RS_FILL: begin
          if (step) begin
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + 8'd1;
            end else begin
              j_q <= j_q + 8'd1;
            end
          end
        end
        RS_GLYPH: begin
          if (step) begin
            if (row_q == 3'(GLYPH_ROWS - 1)) begin
              row_q <= '0;
              col_q <= col_q + 3'd1;
            end else begin
              row_q <= row_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Drawing engine over a 1-bit page-ordered framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command word: op_i
//   selects clear, invert, pixel, line, outline or filled rectangle, circle,
//   glyph or byte read. Output channel (out_valid_o / out_stall_i) returns
//   one word per command: read_data_o holds the byte for a read, 0 otherwise.
//   One command is worked on at a time; the next is taken only when the
//   output register is empty or its word leaves in the same cycle.
//   Clear and invert sweep all N = DisplayWidth * ceil(DisplayHeight / 8) bytes;
//   drawn shapes step one pixel at a time, each on-screen pixel costing a
//   read-modify-write of its byte that holds off the next pixel, while
//   clipped pixels skip the memory. Glyphs step through every font cell and
//   send only the set cells to the memory.
//   After reset all N bytes (1024 by default) are swept to zero before the
//   first command is taken. A stalled result holds until taken and holds off
//   the next command meanwhile.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
  parameter int DisplayWidth  = mfb_pkg::DisplayWidthDef,
  parameter int DisplayHeight = mfb_pkg::DisplayHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        op_i,
  input  logic signed [8:0] x_a_i,
  input  logic signed [8:0] y_a_i,
  input  logic signed [8:0] x_b_i,
  input  logic signed [8:0] y_b_i,
  input  logic [7:0]        radius_i,
  input  logic              pixel_on_i,
  input  logic [7:0]        char_code_i,
  input  logic [9:0]        byte_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o
);
  import mfb_pkg::*;

  top_state_e state_q, state_d;
  logic       out_valid_q, is_read_q;
  logic [7:0] read_data_q;

  op_e        op;
  logic       accept, out_free, st_ready, rast_idle, pt_valid;
  logic       req_valid, rast_start, res_valid;
  logic [7:0] res_data, st_rdata;
  store_req_t req;
  point_t     pt;

  assign op         = op_e'(op_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == TS_IDLE) && st_ready && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR, OP_INVERT, OP_READ: state_d = TS_STORE;
            OP_PIXEL, OP_LINE, OP_RECT, OP_FILL, OP_CIRCLE, OP_GLYPH: state_d = TS_DRAW;
            default: state_d = TS_IDLE;
          endcase
        end
      end
      TS_STORE: if (st_ready) state_d = TS_IDLE;
      TS_DRAW:  if (rast_idle && st_ready) state_d = TS_IDLE;
      default:  state_d = TS_IDLE;
    endcase
  end

  // Route requests and produce results
  always_comb begin
    req_valid  = 1'b0;
    req        = '{kind: REQ_PLOT, x: pt.x, y: pt.y, on: pt.on, addr: byte_index_i};
    rast_start = 1'b0;
    res_valid  = 1'b0;
    res_data   = 8'd0;
    unique case (state_q)
      TS_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: begin
              req_valid = 1'b1;
              req.kind  = REQ_CLEAR;
            end
            OP_INVERT: begin
              req_valid = 1'b1;
              req.kind  = REQ_INVERT;
            end
            OP_READ: begin
              req_valid = 1'b1;
              req.kind  = REQ_READ;
            end
            OP_PIXEL, OP_LINE, OP_RECT, OP_FILL, OP_CIRCLE, OP_GLYPH: rast_start = 1'b1;
            default: res_valid = 1'b1;
          endcase
        end
      end
      TS_STORE: begin
        res_valid = st_ready;
        res_data  = is_read_q ? st_rdata : 8'd0;
      end
      TS_DRAW: begin
        req_valid = pt_valid;
        res_valid = rast_idle && st_ready;
      end
      default: ;
    endcase
  end

  mfb_store #(
    .DisplayWidth (DisplayWidth),
    .DisplayHeight(DisplayHeight)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .ready_o    (st_ready),
    .rdata_o    (st_rdata)
  );

  mfb_raster u_raster (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rast_start),
    .op_i       (op),
    .x_a_i      (x_a_i),
    .y_a_i      (y_a_i),
    .x_b_i      (x_b_i),
    .y_b_i      (y_b_i),
    .radius_i   (radius_i),
    .pixel_on_i (pixel_on_i),
    .char_code_i(char_code_i),
    .pt_valid_o (pt_valid),
    .pt_o       (pt),
    .pt_ready_i (st_ready),
    .idle_o     (rast_idle)
  );

  // Control registers; hold the result word while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_read_q <= op == OP_READ;
    end
    if (res_valid) begin
      read_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule

// ===== tb/tb_mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine
// Drives drawing commands into the engine under random idling on both sides,
// keeps a shadow framebuffer updated by its own rasteriser, and checks every
// returned word against the byte that the shadow predicts.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  localparam int Width    = DisplayWidthDef;
  localparam int Height   = DisplayHeightDef;
  localparam int StoreLen = Width * ((Height + 7) / 8);
  localparam int WatchdogLimit = 600000;

  typedef struct {
    logic [3:0]        op;
    logic signed [8:0] xa;
    logic signed [8:0] ya;
    logic signed [8:0] xb;
    logic signed [8:0] yb;
    logic [7:0]        radius;
    logic              on;
    logic [7:0]        code;
    logic [9:0]        index;
  } cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [3:0]        op_i = '0;
  logic signed [8:0] x_a_i = '0;
  logic signed [8:0] y_a_i = '0;
  logic signed [8:0] x_b_i = '0;
  logic signed [8:0] y_b_i = '0;
  logic [7:0]        radius_i = '0;
  logic              pixel_on_i = 1'b0;
  logic [7:0]        char_code_i = '0;
  logic [9:0]        byte_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        read_data_o;

  cmd_t       cmd_queue[$];
  logic [7:0] read_queue[$];
  logic [7:0] shadow_fb[StoreLen];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         errors = 0;
  int         idle_cycles = 0;

  mono_framebuffer_draw_engine i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow rasteriser
  function automatic void plot_px(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= Width || y < 0 || y >= Height) return;
    idx = x + (y / 8) * Width;
    if (on) shadow_fb[idx] |= 8'(1 << (y % 8));
    else    shadow_fb[idx] &= ~8'(1 << (y % 8));
  endfunction

  function automatic void trace_line(int xa, int ya, int xb, int yb, bit on);
    int dx, dy, sx, sy, err, e2;
    dx = (xb > xa) ? xb - xa : xa - xb;
    dy = (yb > ya) ? yb - ya : ya - yb;
    sx = (xa < xb) ? 1 : -1;
    sy = (ya < yb) ? 1 : -1;
    err = dx - dy;
    forever begin
      plot_px(xa, ya, on);
      if (xa == xb && ya == yb) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; xa += sx; end
      if (e2 < dx) begin err += dx; ya += sy; end
    end
  endfunction

  function automatic logic [7:0] apply_cmd(cmd_t c);
    int xa, ya, xb, yb, px, py, err, code;
    logic [39:0] font;
    xa = c.xa; ya = c.ya; xb = c.xb; yb = c.yb;
    case (c.op)
      OP_CLEAR:  foreach (shadow_fb[k]) shadow_fb[k] = '0;
      OP_INVERT: foreach (shadow_fb[k]) shadow_fb[k] = ~shadow_fb[k];
      OP_PIXEL:  plot_px(xa, ya, c.on);
      OP_LINE:   trace_line(xa, ya, xb, yb, c.on);
      OP_RECT: begin
        trace_line(xa, ya, xa + xb - 1, ya, c.on);
        trace_line(xa + xb - 1, ya, xa + xb - 1, ya + yb - 1, c.on);
        trace_line(xa + xb - 1, ya + yb - 1, xa, ya + yb - 1, c.on);
        trace_line(xa, ya + yb - 1, xa, ya, c.on);
      end
      OP_FILL: begin
        for (int i = 0; i < xb; i++)
          for (int j = 0; j < yb; j++) plot_px(xa + i, ya + j, c.on);
      end
      OP_CIRCLE: begin
        px = c.radius; py = 0; err = 0;
        while (px >= py) begin
          plot_px(xa + px, ya + py, c.on); plot_px(xa + py, ya + px, c.on);
          plot_px(xa - py, ya + px, c.on); plot_px(xa - px, ya + py, c.on);
          plot_px(xa - px, ya - py, c.on); plot_px(xa - py, ya - px, c.on);
          plot_px(xa + py, ya - px, c.on); plot_px(xa + px, ya - py, c.on);
          if (err <= 0) begin py += 1; err += 2 * py + 1; end
          if (err > 0) begin px -= 1; err -= 2 * px + 1; end
        end
      end
      OP_GLYPH: begin
        code = c.code;
        if (code < GLYPH_FIRST || code > GLYPH_LAST) code = GLYPH_FIRST;
        font = GLYPH_ROM[code - GLYPH_FIRST];
        for (int col = 0; col < GLYPH_COLS; col++)
          for (int row = 0; row < GLYPH_ROWS; row++)
            if (font[8 * (GLYPH_COLS - 1 - col) + row]) plot_px(xa + col, ya + row, 1'b1);
      end
      OP_READ: if (c.index < StoreLen) return shadow_fb[c.index];
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    c.op = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 99);
    // Mostly shapes and reads; clears and inverts kept rare, unused codes rarer
    if (sel < 60)      c.op = 4'($urandom_range(OP_PIXEL, OP_READ));
    else if (sel < 85) c.op = OP_READ;
    else if (sel < 90) c.op = 4'($urandom_range(OP_CLEAR, OP_INVERT));
    c.xa = 9'($urandom_range(0, 511));
    c.ya = 9'($urandom_range(0, 511));
    c.xb = 9'($urandom_range(0, 511));
    c.yb = 9'($urandom_range(0, 511));
    c.radius = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      // Keep most shapes near the screen and small
      c.xa = 9'($signed($urandom_range(0, 150)) - 10);
      c.ya = 9'($signed($urandom_range(0, 80)) - 10);
      c.xb = (c.op == OP_LINE) ? 9'($signed($urandom_range(0, 150)) - 10)
                               : 9'($signed($urandom_range(0, 40)) - 4);
      c.yb = (c.op == OP_LINE) ? 9'($signed($urandom_range(0, 80)) - 10)
                               : 9'($signed($urandom_range(0, 30)) - 4);
      c.radius = 8'($urandom_range(0, 40));
    end
    c.on = 1'($urandom_range(0, 1));
    c.code = 8'($urandom_range(0, 255));
    c.index = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  function automatic cmd_t mk(logic [3:0] op, int xa, int ya, int xb, int yb,
                              int r, bit on, int code, int index);
    cmd_t c;
    c.op = op; c.xa = 9'(xa); c.ya = 9'(ya); c.xb = 9'(xb); c.yb = 9'(yb);
    c.radius = 8'(r); c.on = on; c.code = 8'(code); c.index = 10'(index);
    return c;
  endfunction

  // Driver: present the next word, hold it while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_t c;
          c = cmd_queue.pop_front();
          read_queue.push_back(apply_cmd(c));
          in_valid_i <= 1'b1;
          op_i <= c.op; x_a_i <= c.xa; y_a_i <= c.ya; x_b_i <= c.xb; y_b_i <= c.yb;
          radius_i <= c.radius; pixel_on_i <= c.on; char_code_i <= c.code;
          byte_index_i <= c.index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: compare each returned word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (read_queue.size() == 0) begin
          $display("%0t: unexpected word, actual %02h", $realtime, read_data_o);
          errors++;
        end else begin
          logic [7:0] want;
          want = read_queue.pop_front();
          if (want !== read_data_o) begin
            $display("%0t: read_data mismatch, expected %02h actual %02h",
                     $realtime, want, read_data_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("[mono_framebuffer_draw_engine] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid_i || read_queue.size() > 0) @(posedge clk_i);
  endtask

  task automatic push_phase(int count);
    for (int n = 0; n < count; n++) cmd_queue.push_back(rand_cmd());
    wait_drained();
  endtask

  initial begin
    foreach (shadow_fb[k]) shadow_fb[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 48;
    // Directed: reset contents, extremes, every command and special case
    cmd_queue.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_PIXEL, 127, 63, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_PIXEL, -256, 255, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023));
    cmd_queue.push_back(mk(OP_LINE, -256, -256, 255, 255, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_LINE, 100, 5, 3, 60, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_RECT, 10, 10, 20, 12, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_RECT, 50, 30, -3, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_FILL, 60, 20, 10, 9, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_FILL, 60, 20, -5, 9, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_FILL, 62, 22, 4, 4, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_CIRCLE, 64, 32, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_CIRCLE, 64, 32, 0, 0, 30, 1, 0, 0));
    cmd_queue.push_back(mk(OP_CIRCLE, 0, 0, 0, 0, 255, 1, 0, 0));
    cmd_queue.push_back(mk(OP_GLYPH, 2, 40, 0, 0, 0, 0, 65, 0));
    cmd_queue.push_back(mk(OP_GLYPH, 124, 60, 0, 0, 0, 0, 122, 0));
    cmd_queue.push_back(mk(OP_GLYPH, 20, 40, 0, 0, 0, 0, 255, 0));
    cmd_queue.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 642));
    cmd_queue.push_back(mk(4'd9, 0, 0, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(4'd15, 0, 0, 0, 0, 0, 1, 0, 0));
    cmd_queue.push_back(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 512));
    cmd_queue.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
    // Random phases with shifting idle pressure
    push_phase(190);
    send_idle_pct = 48;
    recv_idle_pct = 15;
    push_phase(190);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_phase(200);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[mono_framebuffer_draw_engine] OK");
    end else begin
      $display("[mono_framebuffer_draw_engine] ERROR");
    end
    $finish;
  end

endmodule
